[rtl/dtsig_pkg.sv]
// dtsig_pkg: shared constants of the diamond tiled stencil index generator
// configuration register indexes and field widths; no dependencies
`default_nettype none
package dtsig_pkg;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int IDX_W      = 12;
    localparam int TH_W       = 7;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEPS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 2'd3;
endpackage
`default_nettype wire

[rtl/diamond_tiled_stencil_index_gen_unit.sv]
// diamond_tiled_stencil_index_gen_unit: diamond tiled (x, y, t) sweep generator
// depends on dtsig_pkg; checked by dtsig_checker
//
// Usage: each transfer on the s_ channel (s_tdata[0] = restart) asks for one
// point; one transfer on the m_ channel answers it. restart = 1 starts the
// sweep over and answers with its first point. m_tlast marks the final point,
// m_tuser = 1 means the sweep is done (all other fields zero) until a restart.
// The cfg channel writes grid_width, grid_height, time_steps and tile_height
// (index 0 to 3); cfg_ready is always high; write only while the block is idle.
// A request is served by a sequencer around one span unit that evaluates one
// tile time slice per cycle while the sequencer scans. A point request passes
// through the ADV state before its result is registered for m_; a done answer
// is registered straight from the idle state. The next request is taken only
// after the result transfer. Moving to the next time slice, every empty time
// slice and every tile change (through the TILE and SCAN states) add steps, so
// the edges of the grid and of the time range add skip steps; a restart adds
// the scan to the first non-empty tile.
// s_tready is low while a request is being worked on and while a result
// waits in the output register, so a stalled receiver holds off new requests.
// Reset (aresetn low, synchronous) restores the configuration registers to 1
// and marks the sweep done.
`default_nettype none
module diamond_tiled_stencil_index_gen_unit
    import dtsig_pkg::*;
#(
    parameter int MAX_GRID        = 4096,
    parameter int MAX_STEPS       = 4096,
    parameter int MAX_TILE_HEIGHT = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // restart [0], zero pad [7:1]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [39:0]                m_tdata,   // x_index, y_index, time_index, pad
    output logic                       m_tlast,   // last_point
    output logic                       m_tuser    // sweep_done
);
    localparam int VW_RAW = $clog2(MAX_GRID + MAX_STEPS) + $clog2(MAX_TILE_HEIGHT) + 4;
    localparam int VW     = (VW_RAW > 15) ? VW_RAW : 15;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TILE = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_ADV  = 2'd3;

    typedef logic signed [VW-1:0] val_t;

    logic [CFG_DATA_W-1:0] gw_reg, gh_reg, ts_reg;
    logic [TH_W-1:0]       th_reg;
    logic [1:0]            state_reg, state_next;
    logic                  seek_reg, seek_next;
    logic                  fin_reg, fin_next;
    logic [2:0]            phase_reg, phase_next;
    val_t                  tc_reg, tc_next, tr_reg, tr_next, bc_reg, bc_next;
    val_t                  st_reg, st_next;
    val_t                  ct_reg, ct_next, cr_reg, cr_next, cc_reg, cc_next;
    val_t                  rx_reg, rx_next, ry_reg, ry_next, rt_reg, rt_next;
    logic                  mv_reg, mv_next, ml_reg, ml_next, md_reg, md_next;
    logic [3*IDX_W-1:0]    mf_reg, mf_next;

    val_t nx, ny, nt, h, l, xo, yo, tb, ox, oy, ot, len, hi, lo, ts, a, hx, hy, mm;
    val_t r0, r1, c0, c1;
    logic [1:0] kind;
    logic band_ok, span_ok, s_acc;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE) && !mv_reg;
    assign s_acc     = s_tvalid && s_tready;
    assign m_tvalid  = mv_reg;
    assign m_tdata   = {4'b0, mf_reg};
    assign m_tlast   = ml_reg;
    assign m_tuser   = md_reg;

    always_comb begin
        nx = (gw_reg > MAX_GRID) ? val_t'(MAX_GRID) : val_t'(gw_reg);
        ny = (gh_reg > MAX_GRID) ? val_t'(MAX_GRID) : val_t'(gh_reg);
        nt = (ts_reg > MAX_STEPS) ? val_t'(MAX_STEPS) : val_t'(ts_reg);
        if (th_reg == '0) h = val_t'(1);
        else if (th_reg > MAX_TILE_HEIGHT) h = val_t'(MAX_TILE_HEIGHT);
        else h = val_t'(th_reg);
        l = h <<< 1;
        // tile origins follow the current tile height
        xo = tc_reg * l;
        yo = tr_reg * l;
        tb = bc_reg * l;
        unique case (phase_reg)
            3'd0: begin ox = xo + h; oy = yo + h; ot = tb - h; len = l; kind = 2'd0; end
            3'd1: begin ox = xo + h; oy = yo; ot = tb; len = h; kind = 2'd1; end
            3'd2: begin ox = xo; oy = yo + h; ot = tb; len = h; kind = 2'd2; end
            3'd3: begin ox = xo; oy = yo; ot = tb; len = l; kind = 2'd0; end
            3'd4: begin ox = xo; oy = yo + h; ot = tb + h; len = h; kind = 2'd1; end
            default: begin ox = xo + h; oy = yo; ot = tb + h; len = h; kind = 2'd2; end
        endcase
        hi = ((ot + len) < nt) ? (ot + len) : nt;
        lo = (ot < 0) ? val_t'(0) : ot;
        ts = (state_reg == ST_ADV) ? ct_reg : st_reg;
        a  = ts - ot;
        mm = (a < (l - a - val_t'(1))) ? a : (l - a - val_t'(1));
        unique case (kind)
            2'd0:    begin hx = mm; hy = mm; end
            2'd1:    begin hx = h - a - val_t'(1); hy = a; end
            default: begin hx = a; hy = h - a - val_t'(1); end
        endcase
        r0 = ((oy - hy) < 0) ? val_t'(0) : (oy - hy);
        r1 = ((oy + hy) < (ny - val_t'(1))) ? (oy + hy) : (ny - val_t'(1));
        c0 = ((ox - hx) < 0) ? val_t'(0) : (ox - hx);
        c1 = ((ox + hx) < (nx - val_t'(1))) ? (ox + hx) : (nx - val_t'(1));
        span_ok = (r0 <= r1) && (c0 <= c1);
        band_ok = (nt != 0) && (tb <= nt - val_t'(1) + l);
    end

    always_comb begin
        state_next = state_reg; seek_next = seek_reg; fin_next = fin_reg;
        phase_next = phase_reg; tc_next = tc_reg; tr_next = tr_reg; bc_next = bc_reg;
        st_next = st_reg; ct_next = ct_reg; cr_next = cr_reg; cc_next = cc_reg;
        rx_next = rx_reg; ry_next = ry_reg; rt_next = rt_reg;
        mv_next = mv_reg && !m_tready; ml_next = ml_reg; md_next = md_reg; mf_next = mf_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_tdata[0]) begin
                        phase_next = '0; tc_next = '0; tr_next = '0; bc_next = '0;
                        ct_next = '0; cr_next = '0; cc_next = '0;
                        seek_next = 1'b1; state_next = ST_TILE;
                    end else if (fin_reg) begin
                        mv_next = 1'b1; mf_next = '0; ml_next = 1'b0; md_next = 1'b1;
                    end else begin
                        rx_next = cc_reg; ry_next = cr_reg; rt_next = ct_reg;
                        seek_next = 1'b0; state_next = ST_ADV;
                    end
                end
            end
            ST_TILE: begin
                st_next = lo;
                state_next = ST_SCAN;
            end
            default: begin
                priority if (!band_ok) begin
                    fin_next = 1'b1; state_next = ST_IDLE; mv_next = 1'b1;
                    if (seek_reg) begin
                        mf_next = '0; ml_next = 1'b0; md_next = 1'b1;
                    end else begin
                        mf_next = {rt_reg[IDX_W-1:0], ry_reg[IDX_W-1:0], rx_reg[IDX_W-1:0]};
                        ml_next = 1'b1; md_next = 1'b0;
                    end
                end else if (state_reg == ST_ADV && span_ok && (cc_reg + val_t'(1) <= c1)) begin
                    cc_next = cc_reg + val_t'(1); fin_next = 1'b0;
                    state_next = ST_IDLE; mv_next = 1'b1;
                    mf_next = {rt_reg[IDX_W-1:0], ry_reg[IDX_W-1:0], rx_reg[IDX_W-1:0]};
                    ml_next = 1'b0; md_next = 1'b0;
                end else if (state_reg == ST_ADV && span_ok && (cr_reg + val_t'(1) <= r1)) begin
                    cr_next = cr_reg + val_t'(1); cc_next = c0; fin_next = 1'b0;
                    state_next = ST_IDLE; mv_next = 1'b1;
                    mf_next = {rt_reg[IDX_W-1:0], ry_reg[IDX_W-1:0], rx_reg[IDX_W-1:0]};
                    ml_next = 1'b0; md_next = 1'b0;
                end else if (state_reg == ST_ADV) begin
                    st_next = ct_reg + val_t'(1);
                    state_next = ST_SCAN;
                end else if (st_reg >= hi) begin
                    if (xo <= nx - val_t'(1)) begin
                        tc_next = tc_reg + val_t'(1);
                    end else begin
                        tc_next = '0;
                        if (yo <= ny - val_t'(1)) begin
                            tr_next = tr_reg + val_t'(1);
                        end else begin
                            tr_next = '0;
                            if (phase_reg < 3'd5) begin
                                phase_next = phase_reg + 3'd1;
                            end else begin
                                phase_next = '0; bc_next = bc_reg + val_t'(1);
                            end
                        end
                    end
                    state_next = ST_TILE;
                end else if (span_ok) begin
                    ct_next = st_reg; cr_next = r0; cc_next = c0;
                    if (seek_reg) begin
                        rx_next = c0; ry_next = r0; rt_next = st_reg;
                        seek_next = 1'b0; state_next = ST_ADV;
                    end else begin
                        fin_next = 1'b0; state_next = ST_IDLE; mv_next = 1'b1;
                        mf_next = {rt_reg[IDX_W-1:0], ry_reg[IDX_W-1:0], rx_reg[IDX_W-1:0]};
                        ml_next = 1'b0; md_next = 1'b0;
                    end
                end else begin
                    st_next = st_reg + val_t'(1);
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gw_reg <= CFG_DATA_W'(1); gh_reg <= CFG_DATA_W'(1);
            ts_reg <= CFG_DATA_W'(1); th_reg <= TH_W'(1);
            state_reg <= ST_IDLE; seek_reg <= 1'b0; fin_reg <= 1'b1;
            phase_reg <= '0; tc_reg <= '0; tr_reg <= '0; bc_reg <= '0;
            ct_reg <= '0; cr_reg <= '0; cc_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_GRID_WIDTH:  gw_reg <= cfg_data;
                    REG_GRID_HEIGHT: gh_reg <= cfg_data;
                    REG_TIME_STEPS:  ts_reg <= cfg_data;
                    REG_TILE_HEIGHT: th_reg <= cfg_data[TH_W-1:0];
                    default: ;
                endcase
            end
            state_reg <= state_next; seek_reg <= seek_next; fin_reg <= fin_next;
            phase_reg <= phase_next; tc_reg <= tc_next; tr_reg <= tr_next;
            bc_reg <= bc_next; ct_reg <= ct_next; cr_reg <= cr_next; cc_reg <= cc_next;
            mv_reg <= mv_next;
        end
        st_reg <= st_next;
        rx_reg <= rx_next; ry_reg <= ry_next; rt_reg <= rt_next;
        mf_reg <= mf_next; ml_reg <= ml_next; md_reg <= md_next;
    end
endmodule
`default_nettype wire

[rtl/dtsig_checker.sv]
// dtsig_checker: port level checks of the stencil index generator
// depends on dtsig_pkg; bound to diamond_tiled_stencil_index_gen_unit
`default_nettype none
module dtsig_checker
    import dtsig_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);
    // done results carry no point
    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0 && !m_tlast)
        else $error("done result with nonzero fields");

    // one request in flight at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // no new request while a result waits
    a_hold_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("request taken with result pending");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");
endmodule

bind diamond_tiled_stencil_index_gen_unit dtsig_checker u_dtsig_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire
